// File: design/cefrt_pkg.sv
package cefrt_pkg;

    localparam int DEF_MAX_CONTEXTS = 64;
    localparam int DEF_MAX_EVENTS   = 16;
    localparam logic [31:0] TOTAL_SAT = 32'hFFFF_FFFF;

    localparam logic [1:0] FUNC_OBSERVE = 2'd0;
    localparam logic [1:0] FUNC_SELECT  = 2'd1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    typedef logic [4:0] t_cmd;

    localparam t_cmd CMD_NOP     = 5'd0;
    localparam t_cmd CMD_LOAD    = 5'd1;
    localparam t_cmd CMD_CNEXT   = 5'd2;
    localparam t_cmd CMD_SETSLOT = 5'd3;
    localparam t_cmd CMD_CFAIL   = 5'd4;
    localparam t_cmd CMD_CINS    = 5'd5;
    localparam t_cmd CMD_ILOAD   = 5'd6;
    localparam t_cmd CMD_HINIT   = 5'd7;
    localparam t_cmd CMD_SINIT   = 5'd8;
    localparam t_cmd CMD_WINIT   = 5'd9;
    localparam t_cmd CMD_SELFAIL = 5'd10;
    localparam t_cmd CMD_QRES    = 5'd11;
    localparam t_cmd CMD_HWR     = 5'd12;
    localparam t_cmd CMD_HDONE   = 5'd13;
    localparam t_cmd CMD_ENEXT   = 5'd14;
    localparam t_cmd CMD_FOUND   = 5'd15;
    localparam t_cmd CMD_EFULL   = 5'd16;
    localparam t_cmd CMD_SHINIT  = 5'd17;
    localparam t_cmd CMD_MWR     = 5'd18;
    localparam t_cmd CMD_EINS    = 5'd19;
    localparam t_cmd CMD_INC     = 5'd20;
    localparam t_cmd CMD_WNEXT   = 5'd21;
    localparam t_cmd CMD_WHIT    = 5'd22;
    localparam t_cmd CMD_PUSH    = 5'd23;

    typedef struct packed {
        logic [1:0] func;
        logic       ci_at_used;
        logic       used_full;
        logic       ctx_match;
        logic       total_max;
        logic       draw_ok;
        logic       ei_at_size;
        logic       ev_eq;
        logic       ev_gt;
        logic       size_full;
        logic       ei_at_pos;
        logic       left_gt;
        logic       out_free;
    } t_dp_flags;

endpackage

// File: design/cefrt_ram.sv
module cefrt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH > 1 ? DEPTH : 2)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/cefrt_ctrl.sv
module cefrt_ctrl
    import cefrt_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_dp_flags i_flags,
    output t_cmd      o_cmd
);

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_CRD  = 5'd1;
    localparam logic [4:0] S_CCMP = 5'd2;
    localparam logic [4:0] S_CMIS = 5'd3;
    localparam logic [4:0] S_IRD  = 5'd4;
    localparam logic [4:0] S_ILD  = 5'd5;
    localparam logic [4:0] S_DISP = 5'd6;
    localparam logic [4:0] S_HRD  = 5'd7;
    localparam logic [4:0] S_HWR  = 5'd8;
    localparam logic [4:0] S_SRD  = 5'd9;
    localparam logic [4:0] S_SCMP = 5'd10;
    localparam logic [4:0] S_SEND = 5'd11;
    localparam logic [4:0] S_MRD  = 5'd12;
    localparam logic [4:0] S_MWR  = 5'd13;
    localparam logic [4:0] S_EINS = 5'd14;
    localparam logic [4:0] S_INC  = 5'd15;
    localparam logic [4:0] S_WRD  = 5'd16;
    localparam logic [4:0] S_WCMP = 5'd17;
    localparam logic [4:0] S_OUT  = 5'd18;

    logic [4:0] r_state;
    logic [4:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = CMD_NOP;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd   = CMD_LOAD;
                    n_state = S_CRD;
                end
            end
            S_CRD:  n_state = i_flags.ci_at_used ? S_CMIS : S_CCMP;
            S_CCMP: begin
                if (i_flags.ctx_match) begin
                    o_cmd   = CMD_SETSLOT;
                    n_state = S_IRD;
                end else begin
                    o_cmd   = CMD_CNEXT;
                    n_state = S_CRD;
                end
            end
            S_CMIS: begin
                if (i_flags.used_full) begin
                    o_cmd   = CMD_CFAIL;
                    n_state = S_OUT;
                end else begin
                    o_cmd   = CMD_CINS;
                    n_state = S_DISP;
                end
            end
            S_IRD:  n_state = S_ILD;
            S_ILD: begin
                o_cmd   = CMD_ILOAD;
                n_state = S_DISP;
            end
            S_DISP: begin
                if (i_flags.func == FUNC_OBSERVE) begin
                    if (i_flags.total_max) begin
                        o_cmd   = CMD_HINIT;
                        n_state = S_HRD;
                    end else begin
                        o_cmd   = CMD_SINIT;
                        n_state = S_SRD;
                    end
                end else if (i_flags.func == FUNC_SELECT) begin
                    if (i_flags.draw_ok) begin
                        o_cmd   = CMD_WINIT;
                        n_state = S_WRD;
                    end else begin
                        o_cmd   = CMD_SELFAIL;
                        n_state = S_OUT;
                    end
                end else begin
                    o_cmd   = CMD_QRES;
                    n_state = S_OUT;
                end
            end
            S_HRD: begin
                if (i_flags.ei_at_size) begin
                    o_cmd   = CMD_HDONE;
                    n_state = S_SRD;
                end else begin
                    n_state = S_HWR;
                end
            end
            S_HWR: begin
                o_cmd   = CMD_HWR;
                n_state = S_HRD;
            end
            S_SRD:  n_state = i_flags.ei_at_size ? S_SEND : S_SCMP;
            S_SCMP: begin
                if (i_flags.ev_eq) begin
                    o_cmd   = CMD_FOUND;
                    n_state = S_INC;
                end else if (i_flags.ev_gt) begin
                    n_state = S_SEND;
                end else begin
                    o_cmd   = CMD_ENEXT;
                    n_state = S_SRD;
                end
            end
            S_SEND: begin
                if (i_flags.size_full) begin
                    o_cmd   = CMD_EFULL;
                    n_state = S_OUT;
                end else if (i_flags.ei_at_size) begin
                    n_state = S_EINS;
                end else begin
                    o_cmd   = CMD_SHINIT;
                    n_state = S_MRD;
                end
            end
            S_MRD:  n_state = S_MWR;
            S_MWR: begin
                o_cmd   = CMD_MWR;
                n_state = i_flags.ei_at_pos ? S_EINS : S_MRD;
            end
            S_EINS: begin
                o_cmd   = CMD_EINS;
                n_state = S_INC;
            end
            S_INC: begin
                o_cmd   = CMD_INC;
                n_state = S_OUT;
            end
            S_WRD: begin
                if (i_flags.ei_at_size) begin
                    o_cmd   = CMD_SELFAIL;
                    n_state = S_OUT;
                end else begin
                    n_state = S_WCMP;
                end
            end
            S_WCMP: begin
                if (i_flags.left_gt) begin
                    o_cmd   = CMD_WNEXT;
                    n_state = S_WRD;
                end else begin
                    o_cmd   = CMD_WHIT;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_flags.out_free) begin
                    o_cmd   = CMD_PUSH;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

// File: design/cefrt_dp.sv
module cefrt_dp
    import cefrt_pkg::*;
#(
    parameter int MAX_CONTEXTS = DEF_MAX_CONTEXTS,
    parameter int MAX_EVENTS   = DEF_MAX_EVENTS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_dp_flags   o_flags,
    input  logic [1:0]  i_func,
    input  logic [31:0] i_context_id,
    input  logic [31:0] i_event_value,
    input  logic [31:0] i_draw,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_value,
    output logic [31:0] o_total,
    output logic [4:0]  o_distinct,
    output logic [1:0]  o_status
);

    localparam int CIW = $clog2(MAX_CONTEXTS > 1 ? MAX_CONTEXTS : 2);
    localparam int UW  = $clog2(MAX_CONTEXTS + 1);
    localparam int EIW = $clog2(MAX_EVENTS + 1);
    localparam int ED  = MAX_CONTEXTS * MAX_EVENTS;
    localparam int EAW = $clog2(ED > 1 ? ED : 2);
    localparam int IW  = 32 + EIW;

    logic [1:0]     r_func;
    logic [31:0]    r_id, r_ev, r_draw, r_err;
    logic [UW-1:0]  r_used, r_ci;
    logic [CIW-1:0] r_slot;
    logic [EIW-1:0] r_ei, r_pos, r_size;
    logic [31:0]    r_total, r_sum, r_left, r_cnt;
    logic [31:0]    r_res_value, r_res_total;
    logic [4:0]     r_res_distinct;
    logic [1:0]     r_res_status;
    logic           r_ovalid;
    logic [31:0]    r_o_value, r_o_total;
    logic [4:0]     r_o_distinct;
    logic [1:0]     r_o_status;

    logic [31:0]    ctx_rdata;
    logic [IW-1:0]  info_rdata;
    logic [63:0]    ev_rdata;
    logic [31:0]    ev_id_rd, ev_cnt_rd, half_cnt;

    logic           ctx_we, info_we, ev_we;
    logic [CIW-1:0] info_waddr;
    logic [IW-1:0]  info_wdata;
    logic [EAW-1:0] ev_base, ev_raddr, ev_waddr;
    logic [63:0]    ev_wdata;

    assign ev_id_rd  = ev_rdata[63:32];
    assign ev_cnt_rd = ev_rdata[31:0];
    assign half_cnt  = ev_cnt_rd >> 1;
    assign ev_base   = EAW'(r_slot) * EAW'(MAX_EVENTS);
    assign ev_raddr  = ev_base + EAW'(r_ei);

    always_comb begin
        ctx_we     = (i_cmd == CMD_CINS);
        info_we    = (i_cmd == CMD_CINS) || (i_cmd == CMD_EFULL) || (i_cmd == CMD_INC);
        info_waddr = (i_cmd == CMD_CINS) ? CIW'(r_used) : r_slot;
        case (i_cmd)
            CMD_CINS:  info_wdata = '0;
            CMD_EFULL: info_wdata = {r_size, r_total};
            default:   info_wdata = {r_size, r_total + 32'd1};
        endcase
        ev_we = (i_cmd == CMD_HWR) || (i_cmd == CMD_MWR) || (i_cmd == CMD_INC);
        case (i_cmd)
            CMD_HWR: begin
                ev_waddr = ev_raddr;
                ev_wdata = {ev_id_rd, half_cnt};
            end
            CMD_MWR: begin
                ev_waddr = ev_raddr + EAW'(1);
                ev_wdata = ev_rdata;
            end
            default: begin
                ev_waddr = ev_base + EAW'(r_pos);
                ev_wdata = {r_ev, r_cnt + 32'd1};
            end
        endcase
    end

    cefrt_ram #(.WIDTH(32), .DEPTH(MAX_CONTEXTS)) u_ctx_ram (
        .i_clk   (i_clk),
        .i_we    (ctx_we),
        .i_waddr (CIW'(r_used)),
        .i_wdata (r_id),
        .i_raddr (r_ci[CIW-1:0]),
        .o_rdata (ctx_rdata)
    );

    cefrt_ram #(.WIDTH(IW), .DEPTH(MAX_CONTEXTS)) u_info_ram (
        .i_clk   (i_clk),
        .i_we    (info_we),
        .i_waddr (info_waddr),
        .i_wdata (info_wdata),
        .i_raddr (r_slot),
        .o_rdata (info_rdata)
    );

    cefrt_ram #(.WIDTH(64), .DEPTH(ED)) u_ev_ram (
        .i_clk   (i_clk),
        .i_we    (ev_we),
        .i_waddr (ev_waddr),
        .i_wdata (ev_wdata),
        .i_raddr (ev_raddr),
        .o_rdata (ev_rdata)
    );

    always_comb begin
        o_flags.func       = r_func;
        o_flags.ci_at_used = (r_ci == r_used);
        o_flags.used_full  = (r_used == UW'(MAX_CONTEXTS));
        o_flags.ctx_match  = (ctx_rdata == r_id);
        o_flags.total_max  = (r_total == TOTAL_SAT);
        o_flags.draw_ok    = (r_draw != 32'd0) && (r_draw <= r_total);
        o_flags.ei_at_size = (r_ei == r_size);
        o_flags.ev_eq      = (ev_id_rd == r_ev);
        o_flags.ev_gt      = (ev_id_rd > r_ev);
        o_flags.size_full  = (r_size == EIW'(MAX_EVENTS));
        o_flags.ei_at_pos  = (r_ei == r_pos);
        o_flags.left_gt    = (r_left > ev_cnt_rd);
        o_flags.out_free   = !r_ovalid || i_out_ready;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used   <= '0;
            r_err    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_err <= i_cfg_data;
            end
            if (i_cmd == CMD_CINS) begin
                r_used <= r_used + UW'(1);
            end
            if (i_cmd == CMD_PUSH) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (i_cmd)
            CMD_LOAD: begin
                r_func <= i_func;
                r_id   <= i_context_id;
                r_ev   <= i_event_value;
                r_draw <= i_draw;
                r_ci   <= '0;
            end
            CMD_CNEXT:   r_ci <= r_ci + UW'(1);
            CMD_SETSLOT: r_slot <= r_ci[CIW-1:0];
            CMD_CFAIL: begin
                r_res_value    <= (r_func == FUNC_SELECT) ? r_err : 32'd0;
                r_res_total    <= '0;
                r_res_distinct <= '0;
                r_res_status   <= ST_FULL;
            end
            CMD_CINS: begin
                r_slot  <= CIW'(r_used);
                r_total <= '0;
                r_size  <= '0;
            end
            CMD_ILOAD: begin
                r_total <= info_rdata[31:0];
                r_size  <= info_rdata[IW-1:32];
            end
            CMD_HINIT: begin
                r_ei  <= '0;
                r_sum <= '0;
            end
            CMD_SINIT: r_ei <= '0;
            CMD_WINIT: begin
                r_ei   <= '0;
                r_left <= r_draw;
            end
            CMD_SELFAIL: begin
                r_res_value    <= r_err;
                r_res_total    <= r_total;
                r_res_distinct <= 5'(r_size);
                r_res_status   <= ST_RANGE;
            end
            CMD_QRES: begin
                r_res_value    <= '0;
                r_res_total    <= r_total;
                r_res_distinct <= 5'(r_size);
                r_res_status   <= ST_OK;
            end
            CMD_HWR: begin
                r_sum <= r_sum + half_cnt;
                r_ei  <= r_ei + EIW'(1);
            end
            CMD_HDONE: begin
                r_total <= r_sum;
                r_ei    <= '0;
            end
            CMD_ENEXT: r_ei <= r_ei + EIW'(1);
            CMD_FOUND: begin
                r_cnt <= ev_cnt_rd;
                r_pos <= r_ei;
            end
            CMD_EFULL: begin
                r_res_value    <= '0;
                r_res_total    <= r_total;
                r_res_distinct <= 5'(r_size);
                r_res_status   <= ST_FULL;
            end
            CMD_SHINIT: begin
                r_pos <= r_ei;
                r_ei  <= r_size - EIW'(1);
            end
            CMD_MWR: begin
                if (r_ei != r_pos) begin
                    r_ei <= r_ei - EIW'(1);
                end
            end
            CMD_EINS: begin
                r_pos  <= r_ei;
                r_cnt  <= '0;
                r_size <= r_size + EIW'(1);
            end
            CMD_INC: begin
                r_total        <= r_total + 32'd1;
                r_res_value    <= r_cnt + 32'd1;
                r_res_total    <= r_total + 32'd1;
                r_res_distinct <= 5'(r_size);
                r_res_status   <= ST_OK;
            end
            CMD_WNEXT: begin
                r_left <= r_left - ev_cnt_rd;
                r_ei   <= r_ei + EIW'(1);
            end
            CMD_WHIT: begin
                r_res_value    <= ev_id_rd;
                r_res_total    <= r_total;
                r_res_distinct <= 5'(r_size);
                r_res_status   <= ST_OK;
            end
            CMD_PUSH: begin
                r_o_value    <= r_res_value;
                r_o_total    <= r_res_total;
                r_o_distinct <= r_res_distinct;
                r_o_status   <= r_res_status;
            end
            default: ;
        endcase
    end

    assign o_out_valid = r_ovalid;
    assign o_value     = r_o_value;
    assign o_total     = r_o_total;
    assign o_distinct  = r_o_distinct;
    assign o_status    = r_o_status;

endmodule

// File: design/context_event_frequency_table.sv
// Context event frequency table.
// Input stream (s_axis_*): one item per operation. tuser carries func
// (observe, select, query); tdata carries context_id, event_value, draw.
// Output stream (m_axis_*): one result item per input item, in order.
// tdata carries value, total, distinct; tuser carries status.
// Config channel (i_cfg_*): writes error_event_value; always ready, and is
// meant to be written only while no item is in flight.
// One item at a time: a new item is taken only after the last result has
// been pushed to the output register. The lookup is a linear scan of the
// context id RAM, one read per stored context compared; the search, the
// select walk, the halving pass and the insert shift visit events one at a
// time (an event is visited at most three times per item). The event RAM
// has a single read port.
// Reset (i_rst_n, synchronous, active low) empties the table (context count
// to zero), clears the config register and drops any pending result. RAM
// contents are left as they are; nothing unwritten is ever read.
// The result sits in an output register; a stalled receiver holds it, and
// the block finishes the next item but holds it until the register frees.
module context_event_frequency_table
    import cefrt_pkg::*;
#(
    parameter int MAX_CONTEXTS = DEF_MAX_CONTEXTS,
    parameter int MAX_EVENTS   = DEF_MAX_EVENTS
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [95:0]  s_axis_tdata,  // context_id[31:0], event_value[63:32], draw[95:64]
    input  logic [1:0]   s_axis_tuser,  // func[1:0]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [71:0]  m_axis_tdata,  // value[31:0], total[63:32], distinct[68:64], zero
    output logic [1:0]   m_axis_tuser,  // status[1:0]
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [31:0]  i_cfg_data     // error_event_value
);

    t_cmd        cmd;
    t_dp_flags   flags;
    logic [31:0] value, total;
    logic [4:0]  distinct;

    assign o_cfg_ready = 1'b1;

    cefrt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_flags    (flags),
        .o_cmd      (cmd)
    );

    cefrt_dp #(
        .MAX_CONTEXTS (MAX_CONTEXTS),
        .MAX_EVENTS   (MAX_EVENTS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_flags       (flags),
        .i_func        (s_axis_tuser),
        .i_context_id  (s_axis_tdata[31:0]),
        .i_event_value (s_axis_tdata[63:32]),
        .i_draw        (s_axis_tdata[95:64]),
        .i_cfg_we      (i_cfg_valid),
        .i_cfg_data    (i_cfg_data),
        .o_out_valid   (m_axis_tvalid),
        .i_out_ready   (m_axis_tready),
        .o_value       (value),
        .o_total       (total),
        .o_distinct    (distinct),
        .o_status      (m_axis_tuser)
    );

    assign m_axis_tdata = {3'b000, distinct, total, value};

endmodule

// File: design/cefrt_chk.sv
module cefrt_chk
    import cefrt_pkg::*;
#(
    parameter int MAX_EVENTS = DEF_MAX_EVENTS
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [71:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // one item at a time: busy right after accept
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while busy");

    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tuser != 2'd3)
        else $error("unknown status code");

    a_distinct: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && MAX_EVENTS < 32 |-> m_axis_tdata[68:64] <= 5'(MAX_EVENTS))
        else $error("distinct count above limit");

endmodule

bind context_event_frequency_table cefrt_chk #(.MAX_EVENTS(MAX_EVENTS)) u_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
